// ----- hdl/goi_pkg.sv -----
// ---------------------------------------------------------------------------
// goi_pkg: shared types and constants for grid obstacle inflation
// Grid geometry, cell codes and the request/response payload structs.
// ---------------------------------------------------------------------------
package goi_pkg;

  // Grid geometry
  localparam int GRID_WIDTH    = 20;
  localparam int GRID_CELLS    = 1000;
  localparam int WINDOW_RADIUS = 2;

  // Field widths
  localparam int INDEX_W = 10;
  localparam int VALUE_W = 8;

  // Cell codes
  localparam logic [VALUE_W-1:0] FREE_VALUE     = 8'd255;
  localparam logic [VALUE_W-1:0] INFLATED_VALUE = 8'd200;

  // Request actions
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Window scan
  localparam int WIN_SPAN = 2 * WINDOW_RADIUS + 1;
  localparam int CNT_W    = $clog2(WIN_SPAN);
  // linear address of a window tap is carried biased so it never goes negative
  localparam int BIAS     = WINDOW_RADIUS * GRID_WIDTH + WINDOW_RADIUS;
  localparam int LIN_W    = $clog2(GRID_CELLS + 2 * BIAS);

  // Column arithmetic
  localparam int COL_W  = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
  localparam int COLS_W = $clog2(GRID_WIDTH + 2 * WINDOW_RADIUS);

  // Division by GRID_WIDTH: reciprocal underestimates the quotient by at most one
  localparam int RECIP_SHIFT = INDEX_W;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int RECIP       = (1 << RECIP_SHIFT) / GRID_WIDTH;

  typedef struct packed {
    logic               action;
    logic [INDEX_W-1:0] cell_index;
    logic [VALUE_W-1:0] cell_value;
  } req_t;

  typedef struct packed {
    logic [INDEX_W-1:0] result_index;
    logic [VALUE_W-1:0] result_value;
  } rsp_t;

endpackage

// ----- hdl/goi_ram.sv -----
// ---------------------------------------------------------------------------
// goi_ram: generic single-port RAM
// One read or write per cycle, read data registered.
// ---------------------------------------------------------------------------
module goi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- hdl/grid_obstacle_inflation.sv -----
// ---------------------------------------------------------------------------
// grid_obstacle_inflation: occupancy grid with obstacle inflation on read
// Byte grid in one single-port RAM; queries scan the 5x5 window around a cell.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready, req) carries one transaction per
//   item. A write (action 0) stores cell_value at cell_index in the cycle it
//   is accepted and produces no response. A query (action 1) returns on the
//   response channel (rsp_valid/rsp_ready, rsp) the cell value, or 200 when
//   a free cell (255) has a non-free in-grid cell in its window.
//   Indexes at or beyond the grid size are accepted and dropped.
//   A query passes from acceptance through S_DIV and S_MOD, which split the
//   index into row and column, then S_SCAN, which makes one RAM read per
//   window tap (25 taps) through the single memory port, then S_DRAIN and
//   S_DONE, which collect the last read and form the result.
//   No new request is taken until a query's response is loaded; writes go
//   one per cycle while no query is in progress.
//   The response sits in an output register; a new request is taken while
//   it waits. A query that finishes while the previous response is still
//   stalled holds until rsp_ready frees the register.
//   Reset clears control state only; grid contents are undefined until
//   written and no clearing pass runs.
// ---------------------------------------------------------------------------
module grid_obstacle_inflation (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  goi_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output goi_pkg::rsp_t rsp
);

  import goi_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_DRAIN = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]                 state;
  logic [INDEX_W-1:0]         idx;
  logic [INDEX_W-1:0]         quot;
  logic [COL_W-1:0]           col;
  logic [LIN_W-1:0]           lin;
  logic [CNT_W-1:0]           row_cnt;
  logic [CNT_W-1:0]           col_cnt;
  logic                       rd_pend;
  logic                       centre_pend;
  logic                       blocked;
  logic [VALUE_W-1:0]         centre_val;

  logic                       req_fire;
  logic                       req_in_range;
  logic                       rsp_load;
  logic [INDEX_W+RECIP_W-1:0] recip_prod;
  logic [INDEX_W+COL_W:0]     quot_times_w;
  logic [INDEX_W-1:0]         rem;
  logic [INDEX_W-1:0]         rem_fix;
  logic [COLS_W-1:0]          c_off;
  logic                       in_grid;
  logic [LIN_W-1:0]           lin_addr;
  logic                       last_col;
  logic                       last_tap;
  logic                       ram_we;
  logic [INDEX_W-1:0]         ram_addr;
  logic [VALUE_W-1:0]         ram_rdata;

  // request handshake
  assign req_ready    = (state == S_IDLE);
  assign req_fire     = req_valid && req_ready;
  assign req_in_range = ({1'b0, req.cell_index} < (INDEX_W+1)'(GRID_CELLS));
  assign rsp_load     = (state == S_DONE) && (!rsp_valid || rsp_ready);

  // index to column: reciprocal multiply, then one correction step
  always_comb begin
    recip_prod   = idx * RECIP_W'(RECIP);
    quot_times_w = quot * (COL_W+1)'(GRID_WIDTH);
    rem          = idx - quot_times_w[INDEX_W-1:0];
    rem_fix      = (rem >= INDEX_W'(GRID_WIDTH)) ? rem - INDEX_W'(GRID_WIDTH) : rem;
  end

  // window tap address and grid-edge check
  always_comb begin
    c_off    = COLS_W'(col) + COLS_W'(col_cnt);
    lin_addr = lin - LIN_W'(BIAS);
    in_grid  = (c_off >= COLS_W'(WINDOW_RADIUS)) &&
               (c_off < COLS_W'(GRID_WIDTH + WINDOW_RADIUS)) &&
               (lin >= LIN_W'(BIAS)) &&
               (lin < LIN_W'(GRID_CELLS + BIAS));
    last_col = (col_cnt == CNT_W'(WIN_SPAN - 1));
    last_tap = last_col && (row_cnt == CNT_W'(WIN_SPAN - 1));
  end

  // memory port: writes from the request, reads from the scan
  assign ram_we   = req_fire && (req.action == ACT_WRITE) && req_in_range;
  assign ram_addr = (state == S_IDLE) ? req.cell_index : lin_addr[INDEX_W-1:0];

  goi_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (GRID_CELLS)
  ) u_grid_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (req.cell_value),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid   <= 1'b0;
      rd_pend     <= 1'b0;
      centre_pend <= 1'b0;
    end else begin
      rd_pend     <= (state == S_SCAN) && in_grid;
      centre_pend <= (state == S_SCAN) &&
                     (row_cnt == CNT_W'(WINDOW_RADIUS)) &&
                     (col_cnt == CNT_W'(WINDOW_RADIUS));
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_fire && (req.action == ACT_QUERY) && req_in_range) begin
            state <= S_DIV;
          end
        end
        S_DIV:   state <= S_MOD;
        S_MOD:   state <= S_SCAN;
        S_SCAN: begin
          if (last_tap) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: state <= S_DONE;
        S_DONE: begin
          if (rsp_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        idx     <= req.cell_index;
        blocked <= 1'b0;
      end
      S_DIV: quot <= recip_prod[RECIP_SHIFT +: INDEX_W];
      S_MOD: begin
        col     <= rem_fix[COL_W-1:0];
        lin     <= LIN_W'(idx);
        row_cnt <= '0;
        col_cnt <= '0;
      end
      S_SCAN: begin
        if (last_col) begin
          col_cnt <= '0;
          row_cnt <= row_cnt + CNT_W'(1);
          lin     <= lin + LIN_W'(GRID_WIDTH + 1) - LIN_W'(WIN_SPAN);
        end else begin
          col_cnt <= col_cnt + CNT_W'(1);
          lin     <= lin + LIN_W'(1);
        end
      end
      default: ;
    endcase

    // collect read data in the cycle after its address
    if (rd_pend && (ram_rdata != FREE_VALUE)) begin
      blocked <= 1'b1;
    end
    if (centre_pend) begin
      centre_val <= ram_rdata;
    end

    // response register
    if (rsp_load) begin
      rsp.result_index <= idx;
      rsp.result_value <= ((centre_val == FREE_VALUE) && blocked) ?
                          INFLATED_VALUE : centre_val;
    end
  end

  // checks
  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_DONE)
    else $error("response raised outside the done state");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_IDLE) && (req.action == ACT_WRITE))
    else $error("grid write outside idle");

  a_scan_bounds: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (row_cnt <= CNT_W'(WIN_SPAN - 1)) &&
                          (col_cnt <= CNT_W'(WIN_SPAN - 1)))
    else $error("window counter out of range");

  a_centre_in_grid: assert property (@(posedge clk) disable iff (rst)
    centre_pend |-> rd_pend)
    else $error("centre tap flagged outside the grid");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for grid_obstacle_inflation
// Loads the occupancy grid with cell writes and queries cells whose whole
// window has been loaded. An inflation scoreboard keeps its own copy of the
// grid and predicts every query answer. It covers corner cells, obstacle
// codes, out-of-grid indexes, random sender/receiver idling and a long
// receiver hold-off.
// ---------------------------------------------------------------------------
module tb;
  import goi_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 500;

  // Tracks grid contents and the answers still owed by the block
  class inflation_checker;
    logic [VALUE_W-1:0] cells [GRID_CELLS];
    rsp_t pending_answers [$];
    int errors;

    // Stored value of a cell after inflation against its in-grid window
    function logic [VALUE_W-1:0] inflated_value(int idx);
      int row, col, r, c;
      bit blocked;
      row = idx / GRID_WIDTH;
      col = idx % GRID_WIDTH;
      blocked = 0;
      for (int dr = -WINDOW_RADIUS; dr <= WINDOW_RADIUS; dr++) begin
        for (int dc = -WINDOW_RADIUS; dc <= WINDOW_RADIUS; dc++) begin
          r = row + dr;
          c = col + dc;
          if (r >= 0 && c >= 0 && c < GRID_WIDTH && r * GRID_WIDTH + c < GRID_CELLS)
            if (cells[r * GRID_WIDTH + c] != FREE_VALUE) blocked = 1;
        end
      end
      return (cells[idx] == FREE_VALUE && blocked) ? INFLATED_VALUE : cells[idx];
    endfunction

    // Accepted request transaction: update grid or queue an answer
    function void note_request(req_t r);
      rsp_t answer;
      if (r.cell_index >= GRID_CELLS) return;
      if (r.action == ACT_WRITE) begin
        cells[r.cell_index] = r.cell_value;
      end else begin
        answer.result_index = r.cell_index;
        answer.result_value = inflated_value(r.cell_index);
        pending_answers = {pending_answers, answer};
      end
    endfunction

    // Accepted response transaction: compare with the oldest answer owed
    function void check_answer(rsp_t got);
      rsp_t want;
      if (pending_answers.size() == 0) begin
        $error("unexpected response: result_index %0d result_value %0d",
               got.result_index, got.result_value);
        errors++;
        return;
      end
      want = pending_answers.pop_front();
      if (got.result_index !== want.result_index) begin
        $error("result_index expected %0d actual %0d", want.result_index, got.result_index);
        errors++;
      end
      if (got.result_value !== want.result_value) begin
        $error("result_value expected %0d actual %0d", want.result_value, got.result_value);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  inflation_checker sb;
  bit loaded [GRID_CELLS];
  int tx_idle_pct;
  int rx_idle_pct;
  bit hold_request;
  int cycles;

  grid_obstacle_inflation uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Monitor: both channels sampled at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && rsp_ready) sb.check_answer(rsp);
      if (req_valid && req_ready) sb.note_request(req);
    end
  end

  // Response side: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    rsp_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 0;
        hold_left = HOLD_CYCLES - 1;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
      @(negedge clk);
    end
  end

  // Mostly free cells so that some windows stay clear
  function automatic logic [VALUE_W-1:0] pick_value();
    int p;
    p = $urandom_range(99);
    if (p < 93) return FREE_VALUE;
    if (p < 95) return '0;
    return VALUE_W'($urandom_range(255));
  endfunction

  // Offer one request transaction; returns at the falling edge after acceptance
  task automatic drive_item(input req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_valid <= 1'b0;
      req <= req_t'($urandom);
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  task automatic write_cell(input int idx, input logic [VALUE_W-1:0] val);
    req_t r;
    r.action = ACT_WRITE;
    r.cell_index = INDEX_W'(idx);
    r.cell_value = val;
    if (idx < GRID_CELLS) loaded[idx] = 1;
    drive_item(r);
  endtask

  task automatic query_cell(input int idx);
    req_t r;
    r.action = ACT_QUERY;
    r.cell_index = INDEX_W'(idx);
    r.cell_value = VALUE_W'($urandom_range(255));
    drive_item(r);
  endtask

  // Random traffic: writes, and queries on fully loaded windows; a query whose
  // window still has a hole loads that cell instead
  task automatic run_random(input int count);
    int done, p, idx, missing, row, col, r, c;
    done = 0;
    while (done < count) begin
      p = $urandom_range(99);
      if (p < 4) begin
        // outside the grid: dropped by the block, not counted
        if ($urandom_range(1)) query_cell($urandom_range(1023, GRID_CELLS));
        else write_cell($urandom_range(1023, GRID_CELLS), VALUE_W'($urandom_range(255)));
      end else if (p < 45) begin
        write_cell($urandom_range(GRID_CELLS - 1), pick_value());
        done++;
      end else begin
        idx = $urandom_range(GRID_CELLS - 1);
        row = idx / GRID_WIDTH;
        col = idx % GRID_WIDTH;
        missing = -1;
        for (int dr = -WINDOW_RADIUS; dr <= WINDOW_RADIUS; dr++) begin
          for (int dc = -WINDOW_RADIUS; dc <= WINDOW_RADIUS; dc++) begin
            r = row + dr;
            c = col + dc;
            if (missing < 0 && r >= 0 && c >= 0 && c < GRID_WIDTH &&
                r * GRID_WIDTH + c < GRID_CELLS && !loaded[r * GRID_WIDTH + c])
              missing = r * GRID_WIDTH + c;
          end
        end
        if (missing >= 0) write_cell(missing, pick_value());
        else query_cell(idx);
        done++;
      end
    end
  endtask

  // Main sequence
  initial begin
    sb = new();
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_request = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Top-left corner: window clipped to 3x3, first all free
    write_cell(0, FREE_VALUE);
    write_cell(1, FREE_VALUE);
    write_cell(2, FREE_VALUE);
    write_cell(20, FREE_VALUE);
    write_cell(21, FREE_VALUE);
    write_cell(22, FREE_VALUE);
    write_cell(40, FREE_VALUE);
    write_cell(41, FREE_VALUE);
    write_cell(42, FREE_VALUE);
    query_cell(0);
    // obstacle at the far corner of the window inflates the free cell
    write_cell(42, '0);
    query_cell(0);
    // an occupied cell reads back unchanged
    write_cell(0, '0);
    query_cell(0);
    // index beyond the grid: no answer
    query_cell(1023);
    // Bottom-right corner: nothing beyond the last row or column counts
    write_cell(957, FREE_VALUE);
    write_cell(958, FREE_VALUE);
    write_cell(959, FREE_VALUE);
    write_cell(977, FREE_VALUE);
    write_cell(978, FREE_VALUE);
    write_cell(979, FREE_VALUE);
    write_cell(997, FREE_VALUE);
    write_cell(998, FREE_VALUE);
    write_cell(999, FREE_VALUE);
    query_cell(999);

    // Random phases with different idling mixes
    tx_idle_pct = 33;
    rx_idle_pct = 72;
    run_random(600);
    tx_idle_pct = 72;
    rx_idle_pct = 33;
    run_random(600);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_request = 1;
    run_random(550);

    req_valid <= 1'b0;
    while (sb.pending_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
